// File: hw/rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned ADDR_W       = 20;
  localparam int unsigned SIZE_W       = 21;
  localparam int unsigned TOTAL_W      = SIZE_W + 1;
  localparam int unsigned TOP_W        = SIZE_W + 2;
  localparam int unsigned ADDR_MAX     = (1 << ADDR_W) - 1;
  localparam int unsigned LIMIT_RESET  = 1048576;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] release_address;
  } ffba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;
    logic              reused;
  } ffba_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] total;
    logic              is_free;
  } ffba_entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ffba_cmd_t;

  typedef struct packed {
    logic scan_done;
  } ffba_status_t;

endpackage

// File: hw/rtl/ffba_ctrl.sv
// Control state machine: request handshake, scan sequencing, result handshake.
`timescale 1ns / 1ps
module ffba_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ffba_pkg::ffba_cmd_t   cmd_o,
  input  ffba_pkg::ffba_status_t status_i
);
  import ffba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/ffba_dp.sv
// Datapath: block table memory, scan pipeline, heap top and result register.
`timescale 1ns / 1ps
module ffba_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffba_pkg::ffba_cmd_t          cmd_i,
  output ffba_pkg::ffba_status_t       status_o,
  input  ffba_pkg::ffba_in_t           in_data_i,
  input  logic                         cfg_we_i,
  input  logic [ffba_pkg::SIZE_W-1:0]  cfg_data_i,
  output ffba_pkg::ffba_out_t          out_data_o
);
  import ffba_pkg::*;

  ffba_entry_t mem_q [MAX_BLOCKS];

  logic [SIZE_W-1:0]  limit_q;
  logic [SIZE_W-1:0]  top_q;
  logic [CNT_W-1:0]   count_q;
  logic               req_type_q;
  logic [TOTAL_W-1:0] total_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CNT_W-1:0]   idx_q;
  logic               rd_vld_q;
  ffba_entry_t        rd_data_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  ffba_entry_t        hit_word_q;
  ffba_out_t          out_q;

  logic               more;
  logic               hit_now;
  logic               issue;
  logic [SIZE_W-1:0]  rd_payload;
  logic [TOTAL_W-1:0] new_base;
  logic [TOTAL_W-1:0] new_payload;
  logic [TOP_W-1:0]   new_top;
  logic               grow_fail;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  ffba_entry_t        wr_word;
  ffba_out_t          res;
  logic               grow;

  assign more       = (idx_q < count_q);
  assign rd_payload = {1'b0, rd_data_q.base} + SIZE_W'(HEADER_BYTES);

  always_comb begin
    if (req_type_q == REQ_ALLOC) begin
      hit_now = rd_vld_q && rd_data_q.is_free && ({1'b0, rd_data_q.total} >= total_q);
    end else begin
      hit_now = rd_vld_q && (addr_q != '0) && (rd_payload == {1'b0, addr_q});
    end
  end

  assign issue = cmd_i.scan && !hit_q && !hit_now && more;

  assign status_o.scan_done = hit_q || (!rd_vld_q && !more) ||
                              ((req_type_q == REQ_FREE) && (addr_q == '0));

  assign new_base    = ({1'b0, top_q} + TOTAL_W'(ALIGN_BYTES - 1)) &
                       ~TOTAL_W'(ALIGN_BYTES - 1);
  assign new_payload = new_base + TOTAL_W'(HEADER_BYTES);
  assign new_top     = {2'b0, top_q} + {1'b0, total_q} + TOP_W'(ALIGN_BYTES);
  assign grow_fail   = (count_q == CNT_W'(MAX_BLOCKS)) ||
                       (new_top > {2'b0, limit_q}) ||
                       (new_payload > TOTAL_W'(ADDR_MAX));

  always_comb begin
    res     = '0;
    wr_en   = 1'b0;
    wr_idx  = hit_idx_q;
    wr_word = hit_word_q;
    grow    = 1'b0;
    if (req_type_q == REQ_ALLOC) begin
      if (hit_q) begin
        wr_en           = 1'b1;
        wr_word.is_free = 1'b0;
        res.granted_address = ADDR_W'(hit_word_q.base + ADDR_W'(HEADER_BYTES));
        res.status      = ST_OK;
        res.reused      = 1'b1;
      end else if (grow_fail) begin
        res.status = ST_OOM;
      end else begin
        wr_en           = 1'b1;
        grow            = 1'b1;
        wr_idx          = count_q[IDX_W-1:0];
        wr_word.base    = new_base[ADDR_W-1:0];
        wr_word.total   = total_q[SIZE_W-1:0];
        wr_word.is_free = 1'b0;
        res.granted_address = new_payload[ADDR_W-1:0];
        res.status      = ST_OK;
      end
    end else begin
      if (addr_q == '0) begin
        res.status = ST_OK;
      end else if (hit_q) begin
        wr_en           = 1'b1;
        wr_word.is_free = 1'b1;
        res.status      = ST_OK;
      end else begin
        res.status = ST_UNKNOWN;
      end
    end
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= SIZE_W'(LIMIT_RESET);
      top_q    <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
        hit_q    <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (hit_now && !hit_q) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.finish && grow) begin
        count_q <= count_q + CNT_W'(1);
        top_q   <= new_top[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= in_data_i.req_type;
      total_q    <= {1'b0, in_data_i.request_size} + TOTAL_W'(HEADER_BYTES);
      addr_q     <= in_data_i.release_address;
    end
    if (issue) begin
      rd_data_q <= mem_q[idx_q[IDX_W-1:0]];
      rd_idx_q  <= idx_q[IDX_W-1:0];
    end
    if (hit_now && !hit_q) begin
      hit_idx_q  <= rd_idx_q;
      hit_word_q <= rd_data_q;
    end
    if (cmd_i.finish && wr_en) begin
      mem_q[wr_idx] <= wr_word;
    end
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_count_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(cmd_i.finish) && ($past(req_type_q) == REQ_ALLOC)))
    else $error("block count changed outside an allocate completion");

  a_hit_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> ({1'b0, hit_idx_q} < count_q))
    else $error("scan hit beyond populated entries");

endmodule

// File: hw/rtl/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator.
`timescale 1ns / 1ps
// First-fit heap allocator without split or coalesce, one request at a time.
// The first-fit scan reads table entries one at a time (up to the current
// block count, at most 64); then the last entry read is checked, the
// controller sees the end of the scan, and the result is committed and
// loaded into the result register. When no entry is read (empty table, or a
// free of address zero) the scan ends without a read. The input stalls until
// the result loads, so a new transaction is taken only after the last one is
// done. The single-port read of the block table sets the transaction rate.
// A finished result waits in its register while the next transaction is
// taken; that transaction's commit waits until the register drains. The heap
// limit register may be written at any idle time; the table memory needs no
// clearing after reset.
module first_fit_block_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ffba_pkg::ffba_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ffba_pkg::ffba_out_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [ffba_pkg::SIZE_W-1:0] cfg_data_i
);
  import ffba_pkg::*;

  ffba_cmd_t    cmd;
  ffba_status_t status;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  ffba_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_data_i (in_data_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .out_data_o(out_data_o)
  );

endmodule

// File: tb/first_fit_block_allocator_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit block allocator with a heap-table predictor.
module first_fit_block_allocator_top_test;
  import ffba_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 7;
  localparam int MAX_GAP          = 7;
  localparam int RANDOM_ITEMS     = 1050;
  localparam int SETTLE_CYCLES    = 80;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam logic [SIZE_W-1:0] LIMIT_MAX = '1;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  ffba_in_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  ffba_out_t         out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [SIZE_W-1:0] cfg_data_i  = '0;

  logic [31:0] blk_base [MAX_BLOCKS];
  logic [31:0] blk_total [MAX_BLOCKS];
  bit          blk_free [MAX_BLOCKS];
  int unsigned blk_count      = 0;
  logic [31:0] heap_top_now   = '0;
  logic [31:0] heap_limit_now = LIMIT_RESET;

  ffba_out_t         expected_q[$];
  logic [ADDR_W-1:0] live_addrs[$];
  logic [ADDR_W-1:0] freed_addrs[$];
  int                error_count   = 0;
  int                idle_cycles   = 0;
  bit                sender_no_gaps = 1'b0;
  bit                sink_no_stall  = 1'b0;
  bit                long_hold_req  = 1'b0;

  first_fit_block_allocator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic ffba_out_t predict_allocator(ffba_in_t req);
    ffba_out_t   res;
    logic [31:0] total;
    logic [31:0] base;
    logic [31:0] new_top;
    res = '0;
    if (req.req_type == REQ_ALLOC) begin
      total = 32'(req.request_size) + HEADER_BYTES;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_total[i] >= total) begin
          blk_free[i] = 1'b0;
          res.granted_address = ADDR_W'(blk_base[i] + HEADER_BYTES);
          res.reused = 1'b1;
          return res;
        end
      end
      base    = (heap_top_now + ALIGN_BYTES - 1) & ~32'(ALIGN_BYTES - 1);
      new_top = heap_top_now + total + ALIGN_BYTES;
      if (blk_count >= MAX_BLOCKS || new_top > heap_limit_now ||
          base + HEADER_BYTES > ADDR_MAX) begin
        res.status = ST_OOM;
        return res;
      end
      blk_base[blk_count]  = base;
      blk_total[blk_count] = total;
      blk_free[blk_count]  = 1'b0;
      blk_count++;
      heap_top_now = new_top;
      res.granted_address = ADDR_W'(base + HEADER_BYTES);
    end else if (req.release_address != '0) begin
      res.status = ST_UNKNOWN;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_base[i] + HEADER_BYTES == 32'(req.release_address)) begin
          blk_free[i] = 1'b1;
          res.status  = ST_OK;
          break;
        end
      end
    end
    return res;
  endfunction

  function automatic ffba_in_t alloc_request(logic [SIZE_W-1:0] size);
    ffba_in_t r;
    r.req_type        = REQ_ALLOC;
    r.request_size    = size;
    r.release_address = ADDR_W'($urandom);
    return r;
  endfunction

  function automatic ffba_in_t free_request(logic [ADDR_W-1:0] addr);
    ffba_in_t r;
    r.req_type        = REQ_FREE;
    r.request_size    = SIZE_W'($urandom);
    r.release_address = addr;
    return r;
  endfunction

  function automatic void check_result(ffba_out_t got);
    ffba_out_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result transaction: address %0h status %0d reused %0d",
             got.granted_address, got.status, got.reused);
      error_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got.granted_address !== want.granted_address) begin
      $error("granted_address: expected %0h, actual %0h",
             want.granted_address, got.granted_address);
      error_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      error_count++;
    end
    if (got.reused !== want.reused) begin
      $error("reused: expected %0d, actual %0d", want.reused, got.reused);
      error_count++;
    end
  endfunction

  task automatic send_request(input ffba_in_t req, output ffba_out_t predicted);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_allocator(req);
    expected_q.push_back(predicted);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_heap_limit(logic [SIZE_W-1:0] value);
    wait_quiet();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    heap_limit_now = 32'(value);
  endtask

  task automatic send_random_request();
    ffba_in_t          req;
    ffba_out_t         res;
    int                pick;
    int                idx;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) req = alloc_request(SIZE_W'($urandom_range(0, 64)));
      else if (pick < 85) req = alloc_request(SIZE_W'($urandom_range(0, 512)));
      else if (pick < 95) req = alloc_request(SIZE_W'($urandom_range(0, 4096)));
      else req = alloc_request({1'b1, 20'($urandom)});
      send_request(req, res);
      if (res.status == ST_OK) begin
        live_addrs.push_back(res.granted_address);
        for (int i = 0; i < freed_addrs.size(); i++) begin
          if (freed_addrs[i] == res.granted_address) begin
            freed_addrs.delete(i);
            break;
          end
        end
      end
    end else if (pick < 80 && live_addrs.size() > 0) begin
      idx  = $urandom_range(0, live_addrs.size() - 1);
      addr = live_addrs[idx];
      live_addrs.delete(idx);
      freed_addrs.push_back(addr);
      send_request(free_request(addr), res);
    end else if (pick < 87 && freed_addrs.size() > 0) begin
      idx = $urandom_range(0, freed_addrs.size() - 1);
      send_request(free_request(freed_addrs[idx]), res);
    end else if (pick < 95) begin
      send_request(free_request(ADDR_W'($urandom)), res);
    end else begin
      send_request(free_request('0), res);
    end
  endtask

  task automatic test_directed_requests();
    ffba_out_t         res;
    logic [ADDR_W-1:0] second_addr;
    send_request(alloc_request('0), res);
    send_request(alloc_request(SIZE_W'(1)), res);
    second_addr = res.granted_address;
    send_request(alloc_request(SIZE_W'(7)), res);
    send_request(free_request(second_addr), res);
    // free the same block again
    send_request(free_request(second_addr), res);
    // one byte too large for the freed block
    send_request(alloc_request(SIZE_W'(2)), res);
    send_request(alloc_request(SIZE_W'(1)), res);
    send_request(free_request('0), res);
    send_request(free_request(ADDR_W'(12345)), res);
    send_request(free_request('1), res);
    send_request(alloc_request('1), res);
    send_request(alloc_request(SIZE_W'(21'h100000)), res);
  endtask

  task automatic test_heap_limit();
    ffba_out_t res;
    write_heap_limit('0);
    send_request(alloc_request(SIZE_W'(100)), res);
    send_request(free_request(ADDR_W'(blk_base[0] + HEADER_BYTES)), res);
    send_request(alloc_request('0), res);
    // new top lands exactly on the limit, then one block past it
    write_heap_limit(SIZE_W'(heap_top_now + 40 + HEADER_BYTES + ALIGN_BYTES));
    send_request(alloc_request(SIZE_W'(40)), res);
    send_request(alloc_request('0), res);
    write_heap_limit(SIZE_W'(LIMIT_RESET));
  endtask

  task automatic test_random_traffic();
    live_addrs  = {};
    freed_addrs = {};
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i]) freed_addrs.push_back(ADDR_W'(blk_base[i] + HEADER_BYTES));
      else live_addrs.push_back(ADDR_W'(blk_base[i] + HEADER_BYTES));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) sender_no_gaps = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    sender_no_gaps = 1'b0;
  endtask

  task automatic test_output_backpressure();
    wait_quiet();
    sender_no_gaps = 1'b1;
    long_hold_req  = 1'b1;
    repeat (24) send_random_request();
    sender_no_gaps = 1'b0;
    wait_quiet();
    repeat (16) send_random_request();
  endtask

  task automatic test_wide_limit();
    write_heap_limit(LIMIT_MAX);
    repeat (40) send_random_request();
  endtask

  initial begin : result_sink
    int stall_cycles;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 49) == 0) sink_no_stall = !sink_no_stall;
        stall_cycles = sink_no_stall ? 0 : $urandom_range(0, MAX_GAP);
        if (stall_cycles > 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_cycles) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_requests();
    test_heap_limit();
    test_random_traffic();
    test_output_backpressure();
    test_wide_limit();
    wait_quiet();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
